FILE: src/tnde_pkg.sv
package tnde_pkg;

    localparam int DICT_CODES  = 4096;
    localparam int TABLE_SLOTS = 8192;
    localparam int TAG_BITS    = 15;

    localparam int TAG_W      = 15;
    localparam int WORD_W     = 16;
    localparam int CODE_W     = 15;
    localparam int KEY_BITS   = WORD_W + TAG_W;
    localparam int SLOT_BITS  = $clog2(TABLE_SLOTS);
    localparam int ENTRY_BITS = 1 + KEY_BITS + CODE_W;

    localparam logic [WORD_W-1:0] CODE_FLAG = 16'h8000;

    localparam logic [63:0] HASH_MULT  = 64'h9E3779B97F4A7C15;
    localparam int          HASH_SHIFT = 29;
    localparam int          HASH_BITS  = HASH_SHIFT + SLOT_BITS;
    localparam int          MULT_LO_W  = HASH_BITS / 2;
    localparam int          MULT_HI_W  = HASH_BITS - MULT_LO_W;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH_HI,
        ST_LOOKUP,
        ST_CHECK,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        RUN_EMPTY,
        RUN_RAW,
        RUN_CODE
    } run_class_t;

    typedef struct packed {
        logic lo_en;
        logic hi_en;
    } hash_ctrl_t;

endpackage

FILE: src/tnde_dict_ram.sv
module tnde_dict_ram #(
    parameter int WIDTH = 47,
    parameter int DEPTH = 8192,
    localparam int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [WIDTH-1:0]     wr_data,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [WIDTH-1:0]     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/tnde_hash.sv
module tnde_hash (
    input  logic                              clk,
    input  tnde_pkg::hash_ctrl_t              ctrl,
    input  logic [tnde_pkg::KEY_BITS-1:0]     key,
    output logic [tnde_pkg::SLOT_BITS-1:0]    slot
);

    localparam logic [tnde_pkg::MULT_LO_W-1:0] MULT_LO =
        tnde_pkg::HASH_MULT[tnde_pkg::MULT_LO_W-1:0];
    localparam logic [tnde_pkg::MULT_HI_W-1:0] MULT_HI =
        tnde_pkg::HASH_MULT[tnde_pkg::HASH_BITS-1:tnde_pkg::MULT_LO_W];
    localparam int PROD_LO_W = tnde_pkg::KEY_BITS + tnde_pkg::MULT_LO_W;
    localparam int PROD_HI_W = tnde_pkg::KEY_BITS + tnde_pkg::MULT_HI_W;

    logic [tnde_pkg::HASH_BITS-1:0] prod_lo_reg;
    logic [tnde_pkg::MULT_HI_W-1:0] prod_hi_reg;
    logic [PROD_LO_W-1:0]           prod_lo_full;
    logic [PROD_HI_W-1:0]           prod_hi_full;
    logic [tnde_pkg::HASH_BITS-1:0] hash_sum;

    // two partial products of the low product bits, one per cycle
    assign prod_lo_full = PROD_LO_W'(key) * PROD_LO_W'(MULT_LO);
    assign prod_hi_full = PROD_HI_W'(key) * PROD_HI_W'(MULT_HI);

    always_ff @(posedge clk)
    begin
        if (ctrl.lo_en)
        begin
            prod_lo_reg <= prod_lo_full[tnde_pkg::HASH_BITS-1:0];
        end
        if (ctrl.hi_en)
        begin
            prod_hi_reg <= prod_hi_full[tnde_pkg::MULT_HI_W-1:0];
        end
    end

    assign hash_sum = {prod_hi_reg, {tnde_pkg::MULT_LO_W{1'b0}}} + prod_lo_reg;
    assign slot     = hash_sum[tnde_pkg::HASH_BITS-1:tnde_pkg::HASH_SHIFT];

endmodule

FILE: src/tag_ngram_dictionary_encoder.sv
// sequence: a flush, or a push onto an empty run, is handled in ST_IDLE; any other
// push steps through two hash multiply steps, table read and compare, with one
// more read and compare per extra probe; s_tready is low until ST_IDLE returns
// reset: after rst_n the dictionary table is cleared one slot per cycle, with
// s_tready low; the run and the code counter reset to empty
module tag_ngram_dictionary_encoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,  // tag[14:0], zero[15]
    input  logic        s_tuser,  // kind[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata   // out_word[15:0]
);

    localparam int SB = tnde_pkg::SLOT_BITS;
    localparam int KB = tnde_pkg::KEY_BITS;
    localparam int CW = tnde_pkg::CODE_W;
    localparam int WW = tnde_pkg::WORD_W;
    localparam int EB = tnde_pkg::ENTRY_BITS;
    localparam logic [SB-1:0] LAST_SLOT = SB'(tnde_pkg::TABLE_SLOTS - 1);

    tnde_pkg::state_t     state_reg, state_next;
    tnde_pkg::run_class_t run_class_reg, run_class_next;
    logic [WW-1:0] run_value_reg, run_value_next;
    logic [CW-1:0] next_code_reg, next_code_next;
    logic [KB-1:0] key_reg, key_next;
    logic [SB-1:0] probe_slot_reg, probe_slot_next;
    logic [SB-1:0] probe_cnt_reg, probe_cnt_next;
    logic [SB-1:0] clr_cnt_reg, clr_cnt_next;
    logic [WW-1:0] emit_word_reg, emit_word_next;
    logic          out_valid_reg;
    logic [WW-1:0] out_word_reg;

    tnde_pkg::hash_ctrl_t hash_ctrl;
    logic [KB-1:0]    hash_key;
    logic [SB-1:0]    hash_slot;
    logic             wr_en;
    logic [SB-1:0]    wr_addr;
    logic [EB-1:0]    wr_data;
    logic [SB-1:0]    rd_addr;
    logic [EB-1:0]    rd_data;

    logic             accept;
    logic [CW-1:0]    tag_in;
    logic [KB-1:0]    acc_key;
    logic             out_free;
    logic             load_out;
    logic [WW-1:0]    load_word;
    logic             ent_valid;
    logic [KB-1:0]    ent_key;
    logic [CW-1:0]    ent_code;
    logic [SB-1:0]    slot_inc;
    logic [CW-1:0]    code_inc;

    assign s_tready = (state_reg == tnde_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign tag_in   = CW'(s_tdata[tnde_pkg::TAG_BITS-1:0]);
    assign acc_key  = {run_value_reg, tag_in};
    assign out_free = !out_valid_reg || m_tready;

    assign ent_valid = rd_data[EB-1];
    assign ent_key   = rd_data[EB-2:CW];
    assign ent_code  = rd_data[CW-1:0];
    assign slot_inc  = (probe_slot_reg == LAST_SLOT) ? '0 : probe_slot_reg + 1'b1;
    assign code_inc  = next_code_reg + 1'b1;

    assign hash_key = (state_reg == tnde_pkg::ST_IDLE) ? acc_key : key_reg;

    tnde_hash u_hash (
        .clk  (clk),
        .ctrl (hash_ctrl),
        .key  (hash_key),
        .slot (hash_slot)
    );

    tnde_dict_ram #(
        .WIDTH (EB),
        .DEPTH (tnde_pkg::TABLE_SLOTS)
    ) u_dict_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next      = state_reg;
        run_class_next  = run_class_reg;
        run_value_next  = run_value_reg;
        next_code_next  = next_code_reg;
        key_next        = key_reg;
        probe_slot_next = probe_slot_reg;
        probe_cnt_next  = probe_cnt_reg;
        clr_cnt_next    = clr_cnt_reg;
        emit_word_next  = emit_word_reg;
        hash_ctrl       = '0;
        wr_en           = 1'b0;
        wr_addr         = probe_slot_reg;
        wr_data         = {1'b1, key_reg, code_inc};
        rd_addr         = probe_slot_reg;
        load_out        = 1'b0;
        load_word       = run_value_reg;

        unique case (state_reg)
            tnde_pkg::ST_CLEAR:
            begin
                wr_en        = 1'b1;
                wr_addr      = clr_cnt_reg;
                wr_data      = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == LAST_SLOT)
                begin
                    state_next = tnde_pkg::ST_IDLE;
                end
            end
            tnde_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser)
                    begin
                        if (run_class_reg != tnde_pkg::RUN_EMPTY)
                        begin
                            run_class_next = tnde_pkg::RUN_EMPTY;
                            run_value_next = '0;
                            if (out_free)
                            begin
                                load_out = 1'b1;
                            end
                            else
                            begin
                                emit_word_next = run_value_reg;
                                state_next     = tnde_pkg::ST_EMIT;
                            end
                        end
                    end
                    else if (run_class_reg == tnde_pkg::RUN_EMPTY)
                    begin
                        run_class_next = tnde_pkg::RUN_RAW;
                        run_value_next = WW'(tag_in);
                    end
                    else
                    begin
                        hash_ctrl.lo_en = 1'b1;
                        key_next        = acc_key;
                        state_next      = tnde_pkg::ST_HASH_HI;
                    end
                end
            end
            tnde_pkg::ST_HASH_HI:
            begin
                hash_ctrl.hi_en = 1'b1;
                state_next      = tnde_pkg::ST_LOOKUP;
            end
            tnde_pkg::ST_LOOKUP:
            begin
                rd_addr         = hash_slot;
                probe_slot_next = hash_slot;
                probe_cnt_next  = '0;
                state_next      = tnde_pkg::ST_CHECK;
            end
            tnde_pkg::ST_CHECK:
            begin
                if (ent_valid && ent_key == key_reg)
                begin
                    run_class_next = tnde_pkg::RUN_CODE;
                    run_value_next = tnde_pkg::CODE_FLAG | WW'(ent_code);
                    state_next     = tnde_pkg::ST_IDLE;
                end
                else if (ent_valid && probe_cnt_reg != LAST_SLOT)
                begin
                    rd_addr         = slot_inc;
                    probe_slot_next = slot_inc;
                    probe_cnt_next  = probe_cnt_reg + 1'b1;
                end
                else
                begin
                    // miss: store the n-gram if a free slot and a code remain
                    if (!ent_valid && next_code_reg < CW'(tnde_pkg::DICT_CODES))
                    begin
                        wr_en          = 1'b1;
                        next_code_next = code_inc;
                    end
                    run_class_next = tnde_pkg::RUN_RAW;
                    run_value_next = WW'(key_reg[CW-1:0]);
                    if (out_free)
                    begin
                        load_out   = 1'b1;
                        state_next = tnde_pkg::ST_IDLE;
                    end
                    else
                    begin
                        emit_word_next = run_value_reg;
                        state_next     = tnde_pkg::ST_EMIT;
                    end
                end
            end
            tnde_pkg::ST_EMIT:
            begin
                load_word = emit_word_reg;
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = tnde_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tnde_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tnde_pkg::ST_CLEAR;
            run_class_reg <= tnde_pkg::RUN_EMPTY;
            run_value_reg <= '0;
            next_code_reg <= '0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            run_class_reg <= run_class_next;
            run_value_reg <= run_value_next;
            next_code_reg <= next_code_next;
            clr_cnt_reg   <= clr_cnt_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg        <= key_next;
        probe_slot_reg <= probe_slot_next;
        probe_cnt_reg  <= probe_cnt_next;
        emit_word_reg  <= emit_word_next;
        if (load_out)
        begin
            out_word_reg <= load_word;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_word_reg;

endmodule
